[rtl/differential_drive_odometry_macros.svh]
// ----------------------------------------------------------------------------
// Differential drive odometry assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// same-cycle implication
`define ODO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/odo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry package
// Shared types, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd5;

    localparam logic [31:0] RST_GAIN_LEFT  = 32'd1717987;
    localparam logic [31:0] RST_GAIN_RIGHT = 32'd1717987;
    localparam logic [31:0] RST_TURN_GAIN  = 32'd34178264;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic {
        KIND_MOTOR,
        KIND_TICK
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_TURN,
        ST_FOLD,
        ST_ROT,
        ST_PROJ,
        ST_DONE
    } t_state;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004757;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/odo_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry front end
// Accepts items, drops the first tick and queues motor and tick work.
// ----------------------------------------------------------------------------
module odo_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic signed [15:0]  i_speed_left,
    input  logic signed [15:0]  i_speed_right,
    input  logic                i_q_full,
    output odo_pkg::t_push      o_push
);

    logic r_ticked;
    logic n_ticked;
    logic accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_ticked          = r_ticked;
        o_push.valid      = 1'b0;
        o_push.item.kind  = i_mode ? odo_pkg::KIND_TICK : odo_pkg::KIND_MOTOR;
        o_push.item.left  = i_speed_left;
        o_push.item.right = i_speed_right;
        if (accept) begin
            if (!i_mode) begin
                o_push.valid = 1'b1;
            end else if (!r_ticked) begin
                n_ticked = 1'b1;
            end else begin
                o_push.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticked <= 1'b0;
        end else begin
            r_ticked <= n_ticked;
        end
    end

endmodule

[rtl/odo_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry work queue
// Two-entry queue between the front end and the pose engine.
// ----------------------------------------------------------------------------
module odo_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  odo_pkg::t_push  i_push,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output odo_pkg::t_item  o_item
);

    odo_pkg::t_item r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/odo_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry pose engine
// Holds speeds, gains and pose; runs the tick sequence with an iterative
// CORDIC and drives the registered result item.
// ----------------------------------------------------------------------------
module odo_back #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_q_valid,
    input  odo_pkg::t_item                      i_q_item,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [31:0]                  o_pos_x,
    output logic signed [31:0]                  o_pos_y,
    output logic [31:0]                         o_heading_out,
    output logic signed [31:0]                  o_turn_step
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    odo_pkg::t_state r_state;
    odo_pkg::t_state n_state;

    logic signed [15:0] r_held_l;
    logic signed [15:0] r_held_r;
    logic [31:0]        r_gain_l;
    logic [31:0]        r_gain_r;
    logic [31:0]        r_turn_gain;
    logic signed [31:0] r_pose_x;
    logic signed [31:0] r_pose_y;
    logic [31:0]        r_pose_h;

    logic signed [48:0] r_pl;
    logic signed [48:0] r_pr;
    logic signed [32:0] r_v;
    logic signed [33:0] r_diff;
    logic [47:0]        r_wprod;
    logic [31:0]        r_w;
    logic               r_neg;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic [CNT_W-1:0]   r_i;
    logic signed [66:0] r_px;
    logic signed [66:0] r_py;

    logic               r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic [31:0]        r_out_h;
    logic signed [31:0] r_out_w;

    logic               out_free;
    logic signed [32:0] dl;
    logic signed [32:0] dr;
    logic signed [33:0] dsum;
    logic signed [66:0] wfull;
    logic [47:0]        wround;
    logic [31:0]        w_now;
    logic [31:0]        ang;
    logic [31:0]        ang_q;
    logic               fold;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] atan_v;
    logic signed [33:0] cval;
    logic signed [33:0] sval;
    logic signed [36:0] dx;
    logic signed [36:0] dy;
    logic signed [36:0] sum_x;
    logic signed [36:0] sum_y;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign out_free = !r_out_valid || i_ready;

    assign dl     = 33'((r_pl + 49'sd32768) >>> 16);
    assign dr     = 33'((r_pr + 49'sd32768) >>> 16);
    assign dsum   = 34'(dl) + 34'(dr);
    assign wfull  = r_diff * $signed({1'b0, r_turn_gain});
    assign wround = r_wprod + 48'h8000;
    assign w_now  = wround[47:16];
    assign ang    = r_pose_h - w_now;
    assign ang_q  = ang + 32'h4000_0000;
    assign fold   = ang_q[31];

    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign atan_v = $signed({2'b00, odo_pkg::atan_entry(5'(r_i))});
    assign cval   = r_neg ? -r_x : r_x;
    assign sval   = r_neg ? -r_y : r_y;

    assign dx     = 37'((r_px + 67'sd536870912) >>> 30);
    assign dy     = 37'((r_py + 67'sd536870912) >>> 30);
    assign sum_x  = 37'(r_pose_x) + dx;
    assign sum_y  = 37'(r_pose_y) + dy;
    assign new_x  = sat32(sum_x);
    assign new_y  = sat32(sum_y);

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            odo_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.kind == odo_pkg::KIND_TICK) begin
                        n_state = odo_pkg::ST_MUL;
                    end
                end
            end
            odo_pkg::ST_MUL:  n_state = odo_pkg::ST_SUM;
            odo_pkg::ST_SUM:  n_state = odo_pkg::ST_TURN;
            odo_pkg::ST_TURN: n_state = odo_pkg::ST_FOLD;
            odo_pkg::ST_FOLD: n_state = odo_pkg::ST_ROT;
            odo_pkg::ST_ROT: begin
                if (r_i == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = odo_pkg::ST_PROJ;
                end
            end
            odo_pkg::ST_PROJ: n_state = odo_pkg::ST_DONE;
            odo_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = odo_pkg::ST_IDLE;
                end
            end
            default: n_state = odo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= odo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            odo_pkg::ST_MUL: begin
                r_pl <= r_held_l * $signed({1'b0, r_gain_l});
                r_pr <= r_held_r * $signed({1'b0, r_gain_r});
            end
            odo_pkg::ST_SUM: begin
                r_v    <= 33'(dsum >>> 1);
                r_diff <= 34'(dr) - 34'(dl);
            end
            odo_pkg::ST_TURN: begin
                r_wprod <= wfull[47:0];
            end
            odo_pkg::ST_FOLD: begin
                r_w   <= w_now;
                r_neg <= fold;
                r_x   <= odo_pkg::CORDIC_GAIN_Q30;
                r_y   <= '0;
                r_z   <= fold ? 34'($signed(ang + 32'h8000_0000))
                              : 34'($signed(ang));
                r_i   <= '0;
            end
            odo_pkg::ST_ROT: begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end
                r_i <= r_i + CNT_W'(1);
            end
            odo_pkg::ST_PROJ: begin
                r_px <= r_v * cval;
                r_py <= r_v * sval;
            end
            default: begin
            end
        endcase
    end

    // held speeds, configuration, pose and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_l    <= '0;
            r_held_r    <= '0;
            r_gain_l    <= odo_pkg::RST_GAIN_LEFT;
            r_gain_r    <= odo_pkg::RST_GAIN_RIGHT;
            r_turn_gain <= odo_pkg::RST_TURN_GAIN;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_pose_h    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop && i_q_item.kind == odo_pkg::KIND_MOTOR) begin
                r_held_l <= i_q_item.left;
                r_held_r <= i_q_item.right;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    odo_pkg::CFG_GAIN_LEFT:     r_gain_l    <= i_cfg_data;
                    odo_pkg::CFG_GAIN_RIGHT:    r_gain_r    <= i_cfg_data;
                    odo_pkg::CFG_TURN_GAIN:     r_turn_gain <= i_cfg_data;
                    odo_pkg::CFG_START_X:       r_pose_x    <= $signed(i_cfg_data);
                    odo_pkg::CFG_START_Y:       r_pose_y    <= $signed(i_cfg_data);
                    odo_pkg::CFG_START_HEADING: r_pose_h    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == odo_pkg::ST_DONE && out_free) begin
                r_pose_x    <= new_x;
                r_pose_y    <= new_y;
                r_pose_h    <= r_pose_h + r_w;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == odo_pkg::ST_DONE && out_free) begin
            r_out_x <= new_x;
            r_out_y <= new_y;
            r_out_h <= r_pose_h + r_w;
            r_out_w <= $signed(r_w);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pos_x       = r_out_x;
    assign o_pos_y       = r_out_y;
    assign o_heading_out = r_out_h;
    assign o_turn_step   = r_out_w;

endmodule

[rtl/differential_drive_odometry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose tracker for a two-wheel robot.
//
// Input channel (i_valid/o_ready) takes items: mode 0 latches the left and
// right speed commands, mode 1 is a clock tick. The first tick after reset
// only starts time and gives no result; each later tick gives one result item
// on the output channel (o_valid/i_ready): saturated x and y, the wrapped
// heading and the turn of this tick.
// A front end takes items into a two-entry queue; the pose engine drains it.
// A motor item only latches the speeds. A tick steps the engine through MUL,
// SUM, TURN, FOLD, ROT (the iterative CORDIC, one rotation per cycle), PROJ
// and DONE; the engine pops no new item until it is back in IDLE.
// The result sits in an output register; while the receiver stalls the
// engine holds its finished tick and the queue keeps taking items until full.
// Reset loads default gains, zero speeds and a zero pose. Configuration is a
// single-cycle write (i_cfg_we, i_cfg_index, i_cfg_data); start registers
// load the pose at once.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_macros.svh"

module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_mode,
    input  logic signed [15:0]              i_speed_left,
    input  logic signed [15:0]              i_speed_right,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [31:0]              o_pos_x,
    output logic signed [31:0]              o_pos_y,
    output logic [31:0]                     o_heading_out,
    output logic signed [31:0]              o_turn_step
);

    odo_pkg::t_push push;
    odo_pkg::t_item q_item;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    odo_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_speed_left  (i_speed_left),
        .i_speed_right (i_speed_right),
        .i_q_full      (q_full),
        .o_push        (push)
    );

    odo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    odo_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_heading_out (o_heading_out),
        .o_turn_step   (o_turn_step)
    );

    `ODO_ASSERT_NOW(a_push_not_full, push.valid, !q_full, "item pushed into full queue")
    `ODO_ASSERT_NOW(a_pop_has_item, q_pop, q_valid, "engine popped an empty queue")
    `ODO_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")

endmodule

[tb/sv/odometry_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry pose checker
// Watches the config port and both item channels, keeps its own dead-reckoning
// pose and compares every output item field by field with the oldest
// predicted pose.
// ----------------------------------------------------------------------------
module odometry_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_mode,
    input  logic signed [15:0] i_speed_left,
    input  logic signed [15:0] i_speed_right,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [31:0]        i_heading_out,
    input  logic signed [31:0] i_turn_step,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_poses_checked
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        heading;
        logic signed [31:0] turn;
    } t_pose;

    logic [31:0]        gain_l, gain_r, turn_k;
    logic signed [15:0] speed_l, speed_r;
    logic               clock_started;
    logic signed [31:0] px, py;
    logic [31:0]        ph;
    t_pose              pose_q[$];

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // rotate unit vector to angle a; returns cos and sin in Q2.30
    task automatic rotate(input logic [31:0] a, output longint c, output longint s);
        longint x, y, z, xs, ys;
        logic   flip;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            a = a + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(a));
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(odo_pkg::atan_entry(5'(i)));
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(odo_pkg::atan_entry(5'(i)));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic advance_pose();
        longint     dl, dr, v, c, s, dx, dy;
        logic [63:0] wp;
        logic [31:0] w;
        t_pose      p;
        dl = (longint'(speed_l) * longint'({32'd0, gain_l}) + 64'sd32768) >>> 16;
        dr = (longint'(speed_r) * longint'({32'd0, gain_r}) + 64'sd32768) >>> 16;
        v  = (dl + dr) >>> 1;
        wp = (64'(dr - dl) * {32'd0, turn_k} + 64'h8000) >> 16;
        w  = wp[31:0];
        rotate(ph - w, c, s);
        dx = (v * c + 64'sd536870912) >>> 30;
        dy = (v * s + 64'sd536870912) >>> 30;
        px = clamp32(longint'(px) + dx);
        py = clamp32(longint'(py) + dy);
        ph = ph + w;
        p.x = px; p.y = py; p.heading = ph; p.turn = w;
        pose_q.push_back(p);
    endtask

    always @(posedge i_clk) begin
        t_pose e;
        if (!i_rst_n) begin
            gain_l = odo_pkg::RST_GAIN_LEFT;
            gain_r = odo_pkg::RST_GAIN_RIGHT;
            turn_k = odo_pkg::RST_TURN_GAIN;
            speed_l = '0; speed_r = '0;
            clock_started = 1'b0;
            px = '0; py = '0; ph = '0;
            pose_q.delete();
            o_errors = 0;
            o_poses_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    odo_pkg::CFG_GAIN_LEFT:     gain_l = i_cfg_data;
                    odo_pkg::CFG_GAIN_RIGHT:    gain_r = i_cfg_data;
                    odo_pkg::CFG_TURN_GAIN:     turn_k = i_cfg_data;
                    odo_pkg::CFG_START_X:       px = i_cfg_data;
                    odo_pkg::CFG_START_Y:       py = i_cfg_data;
                    odo_pkg::CFG_START_HEADING: ph = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pose_q.size() == 0) begin
                    $error("pose item with nothing expected");
                    o_errors++;
                end else begin
                    e = pose_q.pop_front();
                    o_poses_checked++;
                    if (i_pos_x !== e.x) begin
                        $error("pos_x exp %0d got %0d", e.x, i_pos_x); o_errors++;
                    end
                    if (i_pos_y !== e.y) begin
                        $error("pos_y exp %0d got %0d", e.y, i_pos_y); o_errors++;
                    end
                    if (i_heading_out !== e.heading) begin
                        $error("heading_out exp %0h got %0h", e.heading, i_heading_out);
                        o_errors++;
                    end
                    if (i_turn_step !== e.turn) begin
                        $error("turn_step exp %0d got %0d", e.turn, i_turn_step);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode == odo_pkg::KIND_MOTOR) begin
                    speed_l = i_speed_left;
                    speed_r = i_speed_right;
                end else if (!clock_started) begin
                    clock_started = 1'b1;
                end else begin
                    advance_pose();
                end
            end
        end
        o_pending <= pose_q.size();
    end

endmodule

[tb/sv/tb_differential_drive_odometry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Directed extremes and config sweeps, then random motor/tick streams under
// three idling regimes; a side checker predicts and compares every pose.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;

    localparam logic [odo_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [odo_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int DRAIN_CYCLES = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [odo_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_mode;
    logic signed [15:0] i_speed_left;
    logic signed [15:0] i_speed_right;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic [31:0]        o_heading_out;
    logic signed [31:0] o_turn_step;

    int errors, pending, poses_checked;
    int send_idle_pct, recv_idle_pct;
    int items_sent;

    differential_drive_odometry DUT (.*);

    odometry_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_mode(i_mode),
        .i_speed_left(i_speed_left), .i_speed_right(i_speed_right),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_pos_x(o_pos_x), .i_pos_y(o_pos_y),
        .i_heading_out(o_heading_out), .i_turn_step(o_turn_step),
        .o_errors(errors), .o_pending(pending), .o_poses_checked(poses_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send(input odo_pkg::t_kind k, input logic [15:0] l, input logic [15:0] r);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= k;
        i_speed_left  <= l;
        i_speed_right <= r;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [odo_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] d);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2: send(odo_pkg::KIND_MOTOR, 16'($urandom), 16'($urandom));
                3:       send(odo_pkg::KIND_MOTOR, 16'($urandom_range(40) - 20),
                                                   16'($urandom_range(40) - 20));
                default: send(odo_pkg::KIND_TICK, 16'($urandom), 16'($urandom));
            endcase
        end
    endtask

    task automatic random_config();
        cfg_write(odo_pkg::CFG_GAIN_LEFT,
                  ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
        cfg_write(odo_pkg::CFG_GAIN_RIGHT, ($urandom_range(3) == 0) ? 32'd0 : $urandom);
        cfg_write(odo_pkg::CFG_TURN_GAIN, $urandom);
        cfg_write(odo_pkg::CFG_START_X, $urandom);
        cfg_write(odo_pkg::CFG_START_Y, $urandom);
        cfg_write(odo_pkg::CFG_START_HEADING, $urandom);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_mode = 1'b0; i_speed_left = '0; i_speed_right = '0;
        items_sent = 0;
        send_idle_pct = 31;
        recv_idle_pct = 56;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first tick starts time, later ticks move the pose
        send(odo_pkg::KIND_MOTOR, 16'h7FFF, 16'h7FFF);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        send(odo_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF);
        send(odo_pkg::KIND_MOTOR, 16'h8000, 16'h7FFF);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        send(odo_pkg::KIND_MOTOR, 16'h7FFF, 16'h8000);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        // fold boundaries of the heading
        cfg_write(odo_pkg::CFG_START_HEADING, 32'h4000_0000);
        send(odo_pkg::KIND_MOTOR, 16'h1000, 16'h1000);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        cfg_write(odo_pkg::CFG_START_HEADING, 32'hC000_0000);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        cfg_write(odo_pkg::CFG_START_HEADING, 32'h3FFF_FFFF);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        // saturation at both limits, full gains, huge turn wrap
        cfg_write(odo_pkg::CFG_GAIN_LEFT, 32'hFFFF_FFFF);
        cfg_write(odo_pkg::CFG_GAIN_RIGHT, 32'hFFFF_FFFF);
        cfg_write(odo_pkg::CFG_TURN_GAIN, 32'hFFFF_FFFF);
        cfg_write(odo_pkg::CFG_START_X, 32'h7FFF_0000);
        cfg_write(odo_pkg::CFG_START_Y, 32'h8000_0000);
        cfg_write(odo_pkg::CFG_START_HEADING, 32'h0);
        send(odo_pkg::KIND_MOTOR, 16'h7FFF, 16'h7FFF);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        send(odo_pkg::KIND_MOTOR, 16'h8000, 16'h8000);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        send(odo_pkg::KIND_MOTOR, 16'h8000, 16'h7FFF);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        // spare indexes are ignored, zero gains stop motion
        cfg_write(CFG_SPARE_A, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE_B, 32'h0);
        cfg_write(odo_pkg::CFG_GAIN_LEFT, 32'h0);
        cfg_write(odo_pkg::CFG_GAIN_RIGHT, 32'h0);
        cfg_write(odo_pkg::CFG_TURN_GAIN, 32'h0);
        send(odo_pkg::KIND_TICK, 16'h0, 16'h0);
        cfg_write(odo_pkg::CFG_GAIN_LEFT, odo_pkg::RST_GAIN_LEFT);
        cfg_write(odo_pkg::CFG_GAIN_RIGHT, odo_pkg::RST_GAIN_RIGHT);
        cfg_write(odo_pkg::CFG_TURN_GAIN, odo_pkg::RST_TURN_GAIN);
        cfg_write(odo_pkg::CFG_START_X, 32'h0);
        cfg_write(odo_pkg::CFG_START_Y, 32'h0);

        random_phase(430);
        send_idle_pct = 56;
        recv_idle_pct = 31;
        random_config();
        random_phase(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        random_phase(430);
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d motor/tick items, checked %0d poses over three idling regimes",
                 items_sent, poses_checked);
        $display("and config sweeps incl. full gains, saturation and heading folds.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
